FILE: hdl/afrp_pkg.sv
`default_nettype none

package afrp_pkg;

  // Depth of the command queue between the parser and the range unit.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result kinds.
  localparam logic [1:0] KIND_RANGE = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Command operations handed from the parser to the range unit.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_BASE  = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;

  // Frame type byte decoding.
  localparam logic [7:0] TYPE_MASK     = 8'hE0;
  localparam logic [7:0] TYPE_ACK      = 8'hA0;
  localparam logic [7:0] TYPE_NBLK_BIT = 8'h10;

  // One queued command: an optional base load or range, then an optional
  // done or error result.
  typedef struct packed {
    logic [1:0]  op;
    logic        first;
    logic [63:0] val;
    logic [15:0] gap;
    logic        trail_en;
    logic [1:0]  trail_kind;
    logic [15:0] delay;
    logic [8:0]  nr;
    logic [7:0]  nts;
    logic [11:0] used;
  } afrp_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/afrp_front.sv
`default_nettype none

module afrp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [7:0]         data_byte,
  input  wire logic               buffer_last,
  output logic                    push,
  output afrp_pkg::afrp_cmd_t     cmd
);

  localparam logic [3:0] PH_TYPE     = 4'd0;
  localparam logic [3:0] PH_NBLK     = 4'd1;
  localparam logic [3:0] PH_NTS      = 4'd2;
  localparam logic [3:0] PH_LARGEST  = 4'd3;
  localparam logic [3:0] PH_DELAY    = 4'd4;
  localparam logic [3:0] PH_FIRSTLEN = 4'd5;
  localparam logic [3:0] PH_GAP      = 4'd6;
  localparam logic [3:0] PH_BLKLEN   = 4'd7;
  localparam logic [3:0] PH_TSSKIP   = 4'd8;
  localparam logic [3:0] PH_DRAIN    = 4'd9;

  logic [3:0]  phase_r, phase_nxt;
  logic [3:0]  fbl_r, fbl_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  blk_len_r, blk_len_nxt;
  logic [3:0]  lg_len_r, lg_len_nxt;
  logic [7:0]  blocks_r, blocks_nxt;
  logic [7:0]  nts_r, nts_nxt;
  logic [9:0]  skip_r, skip_nxt;
  logic [15:0] gap_r, gap_nxt;
  logic [11:0] bc_r, bc_nxt;
  logic [8:0]  nr_r, nr_nxt;
  logic [15:0] delay_r, delay_nxt;

  logic [63:0] acc_shift;
  logic [3:0]  fbl_dec;
  logic [7:0]  blocks_dec;
  logic [9:0]  skip_dec;
  logic [9:0]  skip_init;
  logic        done;
  logic        bad;
  logic        range_push;
  logic        base_push;
  logic        first_rng;

  assign acc_shift  = {acc_r[55:0], data_byte};
  assign fbl_dec    = fbl_r - 4'd1;
  assign blocks_dec = blocks_r - 8'd1;
  assign skip_dec   = (skip_r != 10'd0) ? (skip_r - 10'd1) : skip_r;
  // Timestamp bytes to skip: 5 for the first, 3 for each further one.
  assign skip_init  = {1'b0, nts_r, 1'b0} + {2'b00, nts_r} + 10'd2;

  // Byte parser: one byte per transfer, at most one command per byte.
  always_comb begin
    phase_nxt   = phase_r;
    fbl_nxt     = fbl_r;
    acc_nxt     = acc_r;
    blk_len_nxt = blk_len_r;
    lg_len_nxt  = lg_len_r;
    blocks_nxt  = blocks_r;
    nts_nxt     = nts_r;
    skip_nxt    = skip_r;
    gap_nxt     = gap_r;
    bc_nxt      = bc_r;
    nr_nxt      = nr_r;
    delay_nxt   = delay_r;
    done        = 1'b0;
    bad         = 1'b0;
    range_push  = 1'b0;
    base_push   = 1'b0;
    first_rng   = 1'b0;

    if (accept && (phase_r != PH_DRAIN)) begin
      bc_nxt = bc_r + 12'd1;
      unique case (phase_r)
        PH_NBLK: begin
          blocks_nxt = data_byte;
          phase_nxt  = PH_NTS;
        end
        PH_NTS: begin
          nts_nxt   = data_byte;
          fbl_nxt   = lg_len_r;
          acc_nxt   = '0;
          phase_nxt = PH_LARGEST;
        end
        PH_LARGEST: begin
          acc_nxt = acc_shift;
          fbl_nxt = fbl_dec;
          if (fbl_dec == 4'd0) begin
            base_push = 1'b1;
            fbl_nxt   = 4'd2;
            phase_nxt = PH_DELAY;
          end
        end
        PH_DELAY: begin
          delay_nxt = {delay_r[7:0], data_byte};
          fbl_nxt   = fbl_dec;
          if (fbl_dec == 4'd0) begin
            fbl_nxt   = blk_len_r;
            acc_nxt   = '0;
            phase_nxt = PH_FIRSTLEN;
          end
        end
        PH_FIRSTLEN: begin
          acc_nxt = acc_shift;
          fbl_nxt = fbl_dec;
          if (fbl_dec == 4'd0) begin
            range_push = 1'b1;
            first_rng  = 1'b1;
            nr_nxt     = 9'd1;
            if (blocks_r != 8'd0) begin
              phase_nxt = PH_GAP;
            end else if (nts_r != 8'd0) begin
              skip_nxt  = skip_init;
              phase_nxt = PH_TSSKIP;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_GAP: begin
          gap_nxt   = gap_r + {8'h00, data_byte};
          fbl_nxt   = blk_len_r;
          acc_nxt   = '0;
          phase_nxt = PH_BLKLEN;
        end
        PH_BLKLEN: begin
          acc_nxt = acc_shift;
          fbl_nxt = fbl_dec;
          if (fbl_dec == 4'd0) begin
            if (acc_shift != 64'd0) begin
              range_push = 1'b1;
              nr_nxt     = nr_r + 9'd1;
              gap_nxt    = '0;
            end
            blocks_nxt = blocks_dec;
            if (blocks_dec != 8'd0) begin
              phase_nxt = PH_GAP;
            end else if (nts_r != 8'd0) begin
              skip_nxt  = skip_init;
              phase_nxt = PH_TSSKIP;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_TSSKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 10'd0) begin
            done = 1'b1;
          end
        end
        default: begin
          // Type byte: start a new frame.
          bc_nxt     = 12'd1;
          nr_nxt     = '0;
          blocks_nxt = '0;
          nts_nxt    = '0;
          skip_nxt   = '0;
          gap_nxt    = '0;
          acc_nxt    = '0;
          fbl_nxt    = '0;
          delay_nxt  = '0;
          if ((data_byte & afrp_pkg::TYPE_MASK) != afrp_pkg::TYPE_ACK) begin
            bad = 1'b1;
          end else begin
            blk_len_nxt = 4'd1 << data_byte[1:0];
            lg_len_nxt  = 4'd1 << data_byte[3:2];
            phase_nxt   = ((data_byte & afrp_pkg::TYPE_NBLK_BIT) != 8'h00) ?
                          PH_NBLK : PH_NTS;
          end
        end
      endcase

      // Closing result of the frame, or an error.
      if (bad || done) begin
        phase_nxt = buffer_last ? PH_TYPE : PH_DRAIN;
      end else if (buffer_last) begin
        phase_nxt = PH_TYPE;
      end
    end else if (accept && buffer_last) begin
      // Trailing bytes end at the last byte of the buffer.
      phase_nxt = PH_TYPE;
    end
  end

  // Command towards the range unit.
  always_comb begin
    cmd            = '0;
    cmd.op         = range_push ? afrp_pkg::OP_RANGE :
                     (base_push ? afrp_pkg::OP_BASE : afrp_pkg::OP_NONE);
    cmd.first      = first_rng;
    cmd.val        = acc_shift;
    cmd.gap        = gap_r;
    cmd.trail_en   = bad || done || buffer_last;
    cmd.trail_kind = (done && !bad) ? afrp_pkg::KIND_DONE : afrp_pkg::KIND_ERROR;
    cmd.delay      = delay_nxt;
    cmd.nr         = nr_nxt;
    cmd.nts        = nts_nxt;
    cmd.used       = bc_nxt;
    push           = accept && (phase_r != PH_DRAIN) &&
                     (range_push || base_push || cmd.trail_en);
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_TYPE;
      fbl_r     <= '0;
      blk_len_r <= 4'd1;
      lg_len_r  <= 4'd1;
      blocks_r  <= '0;
      nts_r     <= '0;
      skip_r    <= '0;
      gap_r     <= '0;
      bc_r      <= '0;
      nr_r      <= '0;
      delay_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      fbl_r     <= fbl_nxt;
      blk_len_r <= blk_len_nxt;
      lg_len_r  <= lg_len_nxt;
      blocks_r  <= blocks_nxt;
      nts_r     <= nts_nxt;
      skip_r    <= skip_nxt;
      gap_r     <= gap_nxt;
      bc_r      <= bc_nxt;
      nr_r      <= nr_nxt;
      delay_r   <= delay_nxt;
    end
  end

  // Field accumulator.
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/afrp_queue.sv
`default_nettype none

module afrp_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire afrp_pkg::afrp_cmd_t push_cmd,
  output logic                     full,
  input  wire logic                pop,
  output afrp_pkg::afrp_cmd_t      pop_cmd,
  output logic                     empty
);

  afrp_pkg::afrp_cmd_t entry_r [afrp_pkg::QDEPTH];

  logic [afrp_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [afrp_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [afrp_pkg::QCNT_W-1:0] count_r;
  logic [afrp_pkg::QCNT_W-1:0] count_nxt;

  assign full    = (count_r == afrp_pkg::QCNT_W'(afrp_pkg::QDEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = entry_r[rd_ptr_r];

  // Occupancy follows each push and pop transfer.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + afrp_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - afrp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + afrp_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + afrp_pkg::QPTR_W'(1);
      end
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("command popped from an empty queue");
`endif

endmodule

`default_nettype wire

FILE: hdl/afrp_back.sv
`default_nettype none

module afrp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire afrp_pkg::afrp_cmd_t q_cmd,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_result_kind,
  output logic [63:0]              out_range_high,
  output logic [63:0]              out_range_low,
  output logic [15:0]              out_ack_delay_raw,
  output logic [8:0]               out_range_total,
  output logic [7:0]               out_timestamp_total,
  output logic [11:0]              out_bytes_used,
  output logic                     out_final_result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LO    = 2'd1;
  localparam logic [1:0] ST_TRAIL = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [63:0] prev_r, prev_nxt;
  logic [63:0] hi_r, hi_nxt;
  logic [63:0] len_r, len_nxt;
  logic        trail_en_r, trail_en_nxt;
  logic [1:0]  trail_kind_r, trail_kind_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [8:0]  nr_r, nr_nxt;
  logic [7:0]  nts_r, nts_nxt;
  logic [11:0] used_r, used_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  okind_r, okind_nxt;
  logic [63:0] ohi_r, ohi_nxt;
  logic [63:0] olo_r, olo_nxt;
  logic [15:0] odelay_r, odelay_nxt;
  logic [8:0]  onr_r, onr_nxt;
  logic [7:0]  onts_r, onts_nxt;
  logic [11:0] oused_r, oused_nxt;
  logic        ofinal_r, ofinal_nxt;

  logic        o_free;
  logic        pop_ok;
  logic [63:0] lo_calc;
  logic [63:0] hi_calc;

  assign o_free  = !ov_r || out_ready;
  assign lo_calc = hi_r - len_r + 64'd1;
  // Below the previous range: previous low minus the running gap minus one.
  assign hi_calc = q_cmd.first ? prev_r : (prev_r + ~{48'h0, q_cmd.gap});

  always_comb begin
    st_nxt         = st_r;
    prev_nxt       = prev_r;
    hi_nxt         = hi_r;
    len_nxt        = len_r;
    trail_en_nxt   = trail_en_r;
    trail_kind_nxt = trail_kind_r;
    delay_nxt      = delay_r;
    nr_nxt         = nr_r;
    nts_nxt        = nts_r;
    used_nxt       = used_r;
    ov_nxt         = ov_r && !out_ready;
    okind_nxt      = okind_r;
    ohi_nxt        = ohi_r;
    olo_nxt        = olo_r;
    odelay_nxt     = odelay_r;
    onr_nxt        = onr_r;
    onts_nxt       = onts_r;
    oused_nxt      = oused_r;
    ofinal_nxt     = ofinal_r;
    pop_ok         = 1'b0;

    // Emit the held result once the output register is free.
    unique case (st_r)
      ST_LO: begin
        if (o_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = afrp_pkg::KIND_RANGE;
          ohi_nxt    = hi_r;
          olo_nxt    = lo_calc;
          odelay_nxt = '0;
          onr_nxt    = '0;
          onts_nxt   = '0;
          oused_nxt  = '0;
          ofinal_nxt = !trail_en_r;
          prev_nxt   = lo_calc;
          st_nxt     = trail_en_r ? ST_TRAIL : ST_IDLE;
        end
      end
      ST_TRAIL: begin
        if (o_free) begin
          ov_nxt     = 1'b1;
          okind_nxt  = trail_kind_r;
          ohi_nxt    = '0;
          olo_nxt    = '0;
          ofinal_nxt = 1'b1;
          if (trail_kind_r == afrp_pkg::KIND_DONE) begin
            odelay_nxt = delay_r;
            onr_nxt    = nr_r;
            onts_nxt   = nts_r;
            oused_nxt  = used_r;
          end else begin
            odelay_nxt = '0;
            onr_nxt    = '0;
            onts_nxt   = '0;
            oused_nxt  = '0;
          end
          st_nxt = ST_IDLE;
          pop_ok = 1'b1;
        end
      end
      default: begin
        pop_ok = 1'b1;
      end
    endcase

    // Take the next command from the queue.
    q_pop = pop_ok && !q_empty;
    if (q_pop) begin
      trail_en_nxt   = q_cmd.trail_en;
      trail_kind_nxt = q_cmd.trail_kind;
      delay_nxt      = q_cmd.delay;
      nr_nxt         = q_cmd.nr;
      nts_nxt        = q_cmd.nts;
      used_nxt       = q_cmd.used;
      unique case (q_cmd.op)
        afrp_pkg::OP_BASE: begin
          prev_nxt = q_cmd.val;
          st_nxt   = q_cmd.trail_en ? ST_TRAIL : ST_IDLE;
        end
        afrp_pkg::OP_RANGE: begin
          hi_nxt  = hi_calc;
          len_nxt = q_cmd.val;
          st_nxt  = ST_LO;
        end
        default: begin
          st_nxt = q_cmd.trail_en ? ST_TRAIL : ST_IDLE;
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Working values and the output register.
  always_ff @(posedge clk) begin
    prev_r       <= prev_nxt;
    hi_r         <= hi_nxt;
    len_r        <= len_nxt;
    trail_en_r   <= trail_en_nxt;
    trail_kind_r <= trail_kind_nxt;
    delay_r      <= delay_nxt;
    nr_r         <= nr_nxt;
    nts_r        <= nts_nxt;
    used_r       <= used_nxt;
    okind_r      <= okind_nxt;
    ohi_r        <= ohi_nxt;
    olo_r        <= olo_nxt;
    odelay_r     <= odelay_nxt;
    onr_r        <= onr_nxt;
    onts_r       <= onts_nxt;
    oused_r      <= oused_nxt;
    ofinal_r     <= ofinal_nxt;
  end

  assign out_valid           = ov_r;
  assign out_result_kind     = okind_r;
  assign out_range_high      = ohi_r;
  assign out_range_low       = olo_r;
  assign out_ack_delay_raw   = odelay_r;
  assign out_range_total     = onr_r;
  assign out_timestamp_total = onts_r;
  assign out_bytes_used      = oused_r;
  assign out_final_result    = ofinal_r;

`ifndef NO_ASSERTIONS
  a_range_waits_for_output: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LO) |=> ((st_r == ST_LO) || (ov_r && (okind_r == afrp_pkg::KIND_RANGE))))
    else $error("range left pending state without being emitted");

  a_base_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_cmd.op == afrp_pkg::OP_BASE) && !q_cmd.trail_en) |=> (st_r == ST_IDLE))
    else $error("base load did not return to idle");
`endif

endmodule

`default_nettype wire

FILE: hdl/ack_frame_range_parser_top.sv
// ACK frame range parser.
// Input channel: one buffer byte per transfer on in_data_byte, starting with
// the frame type byte; in_buffer_last marks the final byte of the buffer.
// Result channel: acknowledged ranges, then a done result carrying the raw
// ack delay, range count, timestamp count and bytes used; an error result
// for a bad type byte or a buffer that ends inside the frame.
// out_final_result marks the last result caused by one input byte.
// Each command is written into the queue, popped into the range unit's
// working registers, and its result loaded into the output register once
// that register is free; a second result of the same byte follows it.
// Throughput: one byte per cycle while the queue is not full. The range
// unit spends more states on a range than on a done or error result; a
// four-entry command queue between the parser and the range unit absorbs
// the difference, and a range needs at least two input bytes.
// Reset returns the parser to wait for a type byte and empties the queue.
// When the receiver stalls, the output register holds its result, the
// queue fills, and in_ready falls once four commands are waiting.
`default_nettype none

module ack_frame_range_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_buffer_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_result_kind,
  output logic [63:0]      out_range_high,
  output logic [63:0]      out_range_low,
  output logic [15:0]      out_ack_delay_raw,
  output logic [8:0]       out_range_total,
  output logic [7:0]       out_timestamp_total,
  output logic [11:0]      out_bytes_used,
  output logic             out_final_result
);

  afrp_pkg::afrp_cmd_t push_cmd;
  afrp_pkg::afrp_cmd_t pop_cmd;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  logic                accept;

  // A byte transfer needs room for its command.
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  // Byte parser.
  afrp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .buffer_last (in_buffer_last),
    .push        (push),
    .cmd         (push_cmd)
  );

  // Command queue.
  afrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  // Range arithmetic and result output.
  afrp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (empty),
    .q_cmd               (pop_cmd),
    .q_pop               (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_range_high      (out_range_high),
    .out_range_low       (out_range_low),
    .out_ack_delay_raw   (out_ack_delay_raw),
    .out_range_total     (out_range_total),
    .out_timestamp_total (out_timestamp_total),
    .out_bytes_used      (out_bytes_used),
    .out_final_result    (out_final_result)
  );

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;

  // Parser phases as the predictor tracks them.
  typedef enum logic [3:0] {
    WAIT_TYPE, GET_NBLK, GET_NTS, GET_LARGEST, GET_DELAY, GET_FIRST_LEN,
    GET_GAP, GET_BLK_LEN, SKIP_TS, DRAIN
  } parse_phase_t;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] high;
    logic [63:0] low;
    logic [15:0] delay;
    logic [8:0]  nranges;
    logic [7:0]  nts;
    logic [11:0] used;
    logic        fin;
  } ack_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_buffer_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [63:0] out_range_high;
  logic [63:0] out_range_low;
  logic [15:0] out_ack_delay_raw;
  logic [8:0]  out_range_total;
  logic [7:0]  out_timestamp_total;
  logic [11:0] out_bytes_used;
  logic        out_final_result;

  int errors = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Frame bytes waiting to be sent as one buffer.
  logic [7:0] frame_q[$];

  // Predictor state of the frame parser.
  parse_phase_t phase = WAIT_TYPE;
  int unsigned  field_left = 0;
  logic [63:0]  field_acc = '0;
  int unsigned  len_bytes = 1;
  int unsigned  largest_bytes = 1;
  logic [7:0]   blocks_todo = '0;
  logic [7:0]   ts_count = '0;
  logic [9:0]   skip_left = '0;
  logic [15:0]  gap_run = '0;
  logic [63:0]  last_low_pn = '0;
  logic [11:0]  byte_cnt = '0;
  logic [8:0]   ranges_cnt = '0;
  logic [15:0]  delay_acc = '0;
  ack_result_t  expected_results[$];

  ack_frame_range_parser_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_buffer_last      (in_buffer_last),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_range_high      (out_range_high),
    .out_range_low       (out_range_low),
    .out_ack_delay_raw   (out_ack_delay_raw),
    .out_range_total     (out_range_total),
    .out_timestamp_total (out_timestamp_total),
    .out_bytes_used      (out_bytes_used),
    .out_final_result    (out_final_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ack_result_t pack_result(logic [1:0] kind, logic [63:0] high,
                                              logic [63:0] low, logic [15:0] delay,
                                              logic [8:0] nranges, logic [7:0] nts,
                                              logic [11:0] used);
    ack_result_t r;
    r.kind    = kind;
    r.high    = high;
    r.low     = low;
    r.delay   = delay;
    r.nranges = nranges;
    r.nts     = nts;
    r.used    = used;
    r.fin     = 1'b0;
    return r;
  endfunction

  // After the first range or a block: move on to the next block or to the
  // timestamps. Returns 1 when the frame is complete.
  function automatic bit blocks_finished();
    if (blocks_todo != 0) begin
      phase = GET_GAP;
      return 1'b0;
    end
    if (ts_count != 0) begin
      skip_left = 10'(5 + 3 * (int'(ts_count) - 1));
      phase = SKIP_TS;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the parser by one accepted byte and queue the results it causes.
  function automatic void predict_byte(logic [7:0] b, logic last);
    ack_result_t res[2];
    int          n = 0;
    int          i;
    bit          done = 1'b0;
    bit          bad = 1'b0;
    logic [63:0] high;
    logic [63:0] low;
    if (phase == DRAIN) begin
      if (last) phase = WAIT_TYPE;
      return;
    end
    byte_cnt++;
    case (phase)
      GET_NBLK: begin
        blocks_todo = b;
        phase = GET_NTS;
      end
      GET_NTS: begin
        ts_count = b;
        field_left = largest_bytes;
        field_acc = '0;
        phase = GET_LARGEST;
      end
      GET_LARGEST: begin
        field_acc = {field_acc[55:0], b};
        field_left--;
        if (field_left == 0) begin
          last_low_pn = field_acc;
          field_left = 2;
          phase = GET_DELAY;
        end
      end
      GET_DELAY: begin
        delay_acc = {delay_acc[7:0], b};
        field_left--;
        if (field_left == 0) begin
          field_left = len_bytes;
          field_acc = '0;
          phase = GET_FIRST_LEN;
        end
      end
      GET_FIRST_LEN: begin
        field_acc = {field_acc[55:0], b};
        field_left--;
        if (field_left == 0) begin
          high = last_low_pn;
          low = high - field_acc + 64'd1;
          res[n] = pack_result(afrp_pkg::KIND_RANGE, high, low, '0, '0, '0, '0);
          n++;
          last_low_pn = low;
          ranges_cnt = 9'd1;
          done = blocks_finished();
        end
      end
      GET_GAP: begin
        gap_run = gap_run + 16'(b);
        field_left = len_bytes;
        field_acc = '0;
        phase = GET_BLK_LEN;
      end
      GET_BLK_LEN: begin
        field_acc = {field_acc[55:0], b};
        field_left--;
        if (field_left == 0) begin
          // A zero-length block leaves its gap in the running sum.
          if (field_acc != 0) begin
            high = last_low_pn - {48'd0, gap_run} - 64'd1;
            low = high - field_acc + 64'd1;
            res[n] = pack_result(afrp_pkg::KIND_RANGE, high, low, '0, '0, '0, '0);
            n++;
            last_low_pn = low;
            ranges_cnt++;
            gap_run = '0;
          end
          blocks_todo--;
          done = blocks_finished();
        end
      end
      SKIP_TS: begin
        if (skip_left != 0) skip_left--;
        if (skip_left == 0) done = 1'b1;
      end
      default: begin
        byte_cnt = 12'd1;
        ranges_cnt = '0;
        blocks_todo = '0;
        ts_count = '0;
        skip_left = '0;
        gap_run = '0;
        last_low_pn = '0;
        field_acc = '0;
        field_left = 0;
        delay_acc = '0;
        if ((b & afrp_pkg::TYPE_MASK) != afrp_pkg::TYPE_ACK) begin
          bad = 1'b1;
        end else begin
          len_bytes = 1 << b[1:0];
          largest_bytes = 1 << b[3:2];
          phase = ((b & afrp_pkg::TYPE_NBLK_BIT) != 0) ? GET_NBLK : GET_NTS;
        end
      end
    endcase

    // Closing result: error on a bad type, done on a finished frame, or an
    // error when the buffer ends inside the frame.
    if (bad || done) begin
      if (bad) res[n] = pack_result(afrp_pkg::KIND_ERROR, '0, '0, '0, '0, '0, '0);
      else res[n] = pack_result(afrp_pkg::KIND_DONE, '0, '0, delay_acc, ranges_cnt,
                                ts_count, byte_cnt);
      n++;
      phase = last ? WAIT_TYPE : DRAIN;
    end else if (last) begin
      res[n] = pack_result(afrp_pkg::KIND_ERROR, '0, '0, '0, '0, '0, '0);
      n++;
      phase = WAIT_TYPE;
    end
    for (i = 0; i < n; i++) begin
      res[i].fin = (i == n - 1);
      expected_results.push_back(res[i]);
    end
  endfunction

  // Offer one byte, with random idle cycles ahead of it, and wait for the
  // transfer. Called and returns at a falling edge.
  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = b;
    in_buffer_last = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame_q();
    int i;
    for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  function automatic logic [63:0] rand_field(int nbytes);
    logic [63:0] v;
    case ($urandom_range(3))
      0: v = '0;
      1: v = '1;
      default: v = {$urandom, $urandom};
    endcase
    if (nbytes < 8) v &= (64'd1 << (8 * nbytes)) - 64'd1;
    return v;
  endfunction

  // Big-endian field of the given width.
  function automatic void push_field(logic [63:0] v, int nbytes);
    int i;
    for (i = nbytes - 1; i >= 0; i--) frame_q.push_back(v[8*i +: 8]);
  endfunction

  // Build and send one buffer. A dense frame has one-byte fields and many
  // nonzero blocks; otherwise the frame is random, sometimes with a bad type
  // byte, sometimes cut short, sometimes followed by trailing bytes.
  task automatic send_random_frame(bit dense);
    int          ll;
    int          mm;
    int          nblk;
    int          nts;
    int          cut;
    int          i;
    bit          with_nblk;
    logic [7:0]  tbyte;
    logic [63:0] len;
    frame_q.delete();
    if (!dense && $urandom_range(99) < 8) begin
      do tbyte = 8'($urandom); while ((tbyte & afrp_pkg::TYPE_MASK) == afrp_pkg::TYPE_ACK);
      frame_q.push_back(tbyte);
      repeat ($urandom_range(3)) frame_q.push_back(8'($urandom));
    end else begin
      ll = dense ? 0 : $urandom_range(3);
      mm = dense ? 0 : $urandom_range(3);
      with_nblk = dense || $urandom_range(1);
      tbyte = afrp_pkg::TYPE_ACK | 8'(ll << 2) | 8'(mm);
      if (with_nblk) tbyte |= afrp_pkg::TYPE_NBLK_BIT;
      frame_q.push_back(tbyte);
      nblk = 0;
      if (with_nblk) begin
        if (dense) nblk = $urandom_range(40, 20);
        else if ($urandom_range(99) < 3) nblk = $urandom_range(48, 16);
        else nblk = $urandom_range(6);
        frame_q.push_back(8'(nblk));
      end
      if (dense || $urandom_range(99) < 55) nts = 0;
      else if ($urandom_range(99) < 5) nts = $urandom_range(40, 10);
      else nts = $urandom_range(3, 1);
      frame_q.push_back(8'(nts));
      push_field(rand_field(1 << ll), 1 << ll);
      push_field({32'd0, $urandom}, 2);
      push_field(rand_field(1 << mm), 1 << mm);
      for (i = 0; i < nblk; i++) begin
        frame_q.push_back(8'($urandom));
        if (dense) len = 64'($urandom_range(255, 1));
        else if ($urandom_range(3) == 0) len = '0;
        else len = rand_field(1 << mm);
        push_field(len, 1 << mm);
      end
      if (nts != 0) repeat (5 + 3 * (nts - 1)) frame_q.push_back(8'($urandom));
    end
    if (!dense && $urandom_range(99) < 15) begin
      cut = $urandom_range(frame_q.size(), 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end else begin
      repeat ($urandom_range(2)) frame_q.push_back(8'($urandom));
    end
    send_frame_q();
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // A bad type byte that is also the last byte of its buffer.
    frame_q = '{8'h00};
    send_frame_q();
    // A bad type byte, then bytes that are ignored up to the last one.
    frame_q = '{8'hFF, 8'hA0, 8'h5A};
    send_frame_q();
    // Shortest frame: one-byte fields, no block count, no timestamps.
    frame_q = '{afrp_pkg::TYPE_ACK, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h01};
    send_frame_q();
    // Zero first length wraps the range, a zero-length block keeps its gap,
    // one timestamp is skipped and a trailing byte is ignored.
    frame_q = '{8'hB0, 8'h02, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
                8'h01, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'hEE};
    send_frame_q();
    // The buffer ends on the byte that completes a range with a block left.
    frame_q = '{8'hB0, 8'h01, 8'h00, 8'h10, 8'h00, 8'h00, 8'h03};
    send_frame_q();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int nbytes);
    int target;
    target = bytes_sent + nbytes;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (bytes_sent < target) send_random_frame(1'b0);
  endtask

  // The receiver holds off for a long stretch while range-heavy frames keep
  // coming, so the command queue fills and the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    repeat (2) send_random_frame(1'b1);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string name, logic [63:0] expv, logic [63:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
      errors++;
    end
  endfunction

  // Compare every result transfer with the oldest expected result.
  always @(posedge clk) begin
    ack_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                 out_result_kind);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("result_kind", 64'(exp_r.kind), 64'(out_result_kind));
        check_field("range_high", exp_r.high, out_range_high);
        check_field("range_low", exp_r.low, out_range_low);
        check_field("ack_delay_raw", 64'(exp_r.delay), 64'(out_ack_delay_raw));
        check_field("range_total", 64'(exp_r.nranges), 64'(out_range_total));
        check_field("timestamp_total", 64'(exp_r.nts), 64'(out_timestamp_total));
        check_field("bytes_used", 64'(exp_r.used), 64'(out_bytes_used));
        check_field("final_result", 64'(exp_r.fin), 64'(out_final_result));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_traffic(0, 0, 120);
    test_random_traffic(86, 0, 120);
    test_random_traffic(0, 86, 120);
    test_random_traffic(10, 10, 120);
    test_backpressure();

    // Drain the remaining results, then wait a while longer for stray results.
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
